[src/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg
// shared constants and codes for the first-fit allocator with compaction
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int MEM_CELLS_DEF = 128;

    localparam int TYPE_W = 2;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int ID_W   = 32;
    localparam int CFG_W  = 8;

    localparam logic [CFG_W-1:0] MEM_SIZE_RST = 8'd128;
    localparam logic [ID_W-1:0]  ID_MAX       = 32'hFFFF_FFFF;

    localparam logic [TYPE_W-1:0] REQ_ALLOC  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_ERASE  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_DEFRAG = 2'd2;

    localparam logic [STAT_W-1:0] ST_GRANT   = 2'd0;
    localparam logic [STAT_W-1:0] ST_NULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_ILLEGAL = 2'd2;

endpackage

[src/ffa_if.sv]
// ----------------------------------------------------------------------------
// ffa_if
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
interface ffa_req_if;
    import ffa_pkg::*;

    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [VAL_W-1:0]  req_value;

    modport source (output valid, output req_type, output req_value, input ready);
    modport sink   (input valid, input req_type, input req_value, output ready);
endinterface

interface ffa_rsp_if;
    import ffa_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   block_id;

    modport source (output valid, output status, output block_id, input ready);
    modport sink   (input valid, input status, input block_id, output ready);
endinterface

[src/ffa_ram.sv]
// ----------------------------------------------------------------------------
// ffa_ram
// simple dual-port ram, one write port, one read port with registered read
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 128,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/first_fit_allocator_with_compaction.sv]
// ----------------------------------------------------------------------------
// first_fit_allocator_with_compaction
// first-fit cell allocator with erase and compaction over a ram of owner ids
// ----------------------------------------------------------------------------
//  channel   dir  handshake     word
//  i_req     in   valid/ready   req_type, req_value
//  o_rsp     out  valid/ready   status, block_id
//  i_cfg_*   in   write enable  mem_size
//
//  alloc scans one cell per cycle through the ram read port, then writes
//  one claimed cell per cycle; erase scans the m cells; defrag packs the
//  used cells down, then clears the freed cells.
//  after reset a clearing pass writes MEM_CELLS cells, one a cycle, with
//  i_req.ready low. a pending response waits in the output register.
// ----------------------------------------------------------------------------
module first_fit_allocator_with_compaction #(
    parameter int MEM_CELLS = ffa_pkg::MEM_CELLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ffa_pkg::CFG_W-1:0]  i_cfg_data,
    ffa_req_if.sink                    i_req,
    ffa_rsp_if.source                  o_rsp
);
    import ffa_pkg::*;

    localparam int AW = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
    localparam int CW = $clog2(MEM_CELLS + 1);
    localparam int SW = (CW > CFG_W) ? CW : CFG_W;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ASCAN = 3'd2;
    localparam logic [2:0] S_AFILL = 3'd3;
    localparam logic [2:0] S_ESCAN = 3'd4;
    localparam logic [2:0] S_DSCAN = 3'd5;
    localparam logic [2:0] S_DZERO = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_rd_ptr, n_rd_ptr;
    logic              r_pend, n_pend;
    logic [AW-1:0]     r_pidx, n_pidx;
    logic [CW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]     r_run, n_run;
    logic [AW-1:0]     r_start, n_start;
    logic [AW-1:0]     r_end, n_end;
    logic              r_hit, n_hit;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [ID_W-1:0]   r_next_id, n_next_id;
    logic [CFG_W-1:0]  r_mem_size;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [ID_W-1:0]   r_res_id, n_res_id;
    logic              r_out_vld, n_out_vld;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [ID_W-1:0]   r_out_id, n_out_id;

    logic [SW-1:0]     w_size_ext;
    logic [CW-1:0]     w_m;
    logic              w_accept;
    logic              w_issue;
    logic [CW-1:0]     w_run_inc;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ID_W-1:0]   ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [ID_W-1:0]   ram_rdata;

    ffa_ram #(
        .WIDTH (ID_W),
        .DEPTH (MEM_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // effective cell count saturates at MEM_CELLS
    assign w_size_ext = SW'(r_mem_size);
    assign w_m = (w_size_ext > SW'(MEM_CELLS)) ? CW'(MEM_CELLS) : CW'(w_size_ext);

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_run_inc   = r_run + CW'(1);

    assign o_rsp.valid    = r_out_vld;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.block_id = r_out_id;

    always_comb begin
        n_state      = r_state;
        n_rd_ptr     = r_rd_ptr;
        n_pend       = 1'b0;
        n_pidx       = r_rd_ptr[AW-1:0];
        n_wr_ptr     = r_wr_ptr;
        n_run        = r_run;
        n_start      = r_start;
        n_end        = r_end;
        n_hit        = r_hit;
        n_val        = r_val;
        n_next_id    = r_next_id;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_out_vld    = r_out_vld && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;

        ram_we    = 1'b0;
        ram_waddr = r_wr_ptr[AW-1:0];
        ram_wdata = '0;
        ram_raddr = r_rd_ptr[AW-1:0];
        w_issue   = (r_rd_ptr < w_m) &&
                    (r_state == S_ASCAN || r_state == S_ESCAN || r_state == S_DSCAN);
        ram_re    = w_issue;

        if (w_issue) begin
            n_pend   = 1'b1;
            n_rd_ptr = r_rd_ptr + CW'(1);
        end

        case (r_state)
            S_CLR: begin
                ram_we   = 1'b1;
                n_wr_ptr = r_wr_ptr + CW'(1);
                if (r_wr_ptr == CW'(MEM_CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_rd_ptr = '0;
                    n_wr_ptr = '0;
                    n_run    = '0;
                    n_hit    = 1'b0;
                    n_val    = i_req.req_value;
                    n_res_id = '0;
                    case (i_req.req_type)
                        REQ_ALLOC: begin
                            if (r_next_id == ID_MAX) begin
                                n_res_status = ST_NULL;
                                n_state      = S_RESP;
                            end else begin
                                n_state = S_ASCAN;
                            end
                        end
                        REQ_ERASE: begin
                            if (i_req.req_value == '0) begin
                                n_res_status = ST_ILLEGAL;
                                n_state      = S_RESP;
                            end else begin
                                n_state = S_ESCAN;
                            end
                        end
                        REQ_DEFRAG: begin
                            n_state = S_DSCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ASCAN: begin
                if (r_pend) begin
                    if (ram_rdata != '0) begin
                        n_run = '0;
                    end else begin
                        n_run = w_run_inc;
                        if (r_run == '0) begin
                            n_start = r_pidx;
                        end
                        if (32'(w_run_inc) >= r_val) begin
                            n_end        = r_pidx;
                            n_next_id    = r_next_id + ID_W'(1);
                            n_res_status = ST_GRANT;
                            n_res_id     = r_next_id + ID_W'(1);
                            n_wr_ptr     = (r_run == '0) ? CW'(r_pidx) : CW'(r_start);
                            n_state      = (r_val == '0) ? S_RESP : S_AFILL;
                        end
                    end
                end else if (r_rd_ptr >= w_m) begin
                    n_res_status = ST_NULL;
                    n_res_id     = '0;
                    n_state      = S_RESP;
                end
            end
            S_AFILL: begin
                ram_we    = 1'b1;
                ram_wdata = r_next_id;
                n_wr_ptr  = r_wr_ptr + CW'(1);
                if (r_wr_ptr[AW-1:0] == r_end) begin
                    n_state = S_RESP;
                end
            end
            S_ESCAN: begin
                if (r_pend) begin
                    if (ram_rdata == r_val) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_pidx;
                        n_hit     = 1'b1;
                    end
                end else if (r_rd_ptr >= w_m) begin
                    if (r_hit) begin
                        n_state = S_IDLE;
                    end else begin
                        n_res_status = ST_ILLEGAL;
                        n_res_id     = '0;
                        n_state      = S_RESP;
                    end
                end
            end
            S_DSCAN: begin
                if (r_pend) begin
                    if (ram_rdata != '0) begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata;
                        n_wr_ptr  = r_wr_ptr + CW'(1);
                    end
                end else if (r_rd_ptr >= w_m) begin
                    n_state = S_DZERO;
                end
            end
            S_DZERO: begin
                if (r_wr_ptr < w_m) begin
                    ram_we   = 1'b1;
                    n_wr_ptr = r_wr_ptr + CW'(1);
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = r_res_id;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_pend     <= 1'b0;
            r_next_id  <= '0;
            r_mem_size <= MEM_SIZE_RST;
            r_out_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_run      <= '0;
        end else begin
            r_state   <= n_state;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_pend    <= n_pend;
            r_next_id <= n_next_id;
            r_out_vld <= n_out_vld;
            r_hit     <= n_hit;
            r_run     <= n_run;
            if (i_cfg_we) begin
                r_mem_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx       <= n_pidx;
        r_start      <= n_start;
        r_end        <= n_end;
        r_val        <= n_val;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
    end

endmodule
